// ===== rtl/fbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants of the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  // Depth of the next-index memory, i.e. the largest pool the unit can hold.
  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 17;
  localparam int CNT_W   = 11;
  localparam int ALIGN_W = 13;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  localparam int SIZE_MAX = 65536;

  // Pool span is at most (2^CNT_W - 1) * 2^(SIZE_W - 1), below 2^(CNT_W + SIZE_W - 1).
  localparam int SPAN_W = CNT_W + SIZE_W;
  localparam int OFF_W  = CNT_W + SIZE_W - 1;
  localparam int HOFF_W = IDX_W + SIZE_W;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_RANGE    = 2'd2,
    ST_MISALIGN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ARENA_BASE  = 2'd0,
    REG_BLOCK_SIZE  = 2'd1,
    REG_BLOCK_COUNT = 2'd2,
    REG_DEF_ALIGN   = 2'd3
  } reg_idx_t;

  // One link of the free list: the following free block, or the end mark.
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] idx;
  } link_t;

  // What the divider hands back at the end of a division.
  typedef struct packed {
    logic             done;
    logic             exact;
    logic [CNT_W-1:0] quot;
  } div_res_t;

endpackage

// ===== rtl/fbfl_ram.sv =====
// ----------------------------------------------------------------------------
// fbfl_ram
// Next-index memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbfl_ram
  import fbfl_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  link_t            wdata,
  input  logic [IDX_W-1:0] raddr,
  output link_t            rdata
);

  link_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fbfl_div.sv =====
// ----------------------------------------------------------------------------
// fbfl_div
// Restoring divider, one quotient bit per cycle, used to turn a byte offset
// into a block index and to check that the offset lands on a block boundary.
// ----------------------------------------------------------------------------
module fbfl_div
  import fbfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OFF_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output div_res_t          res
);

  localparam int STEP_W = $clog2(CNT_W);

  logic [OFF_W-1:0]  rem_r,  rem_nxt;
  logic [OFF_W-1:0]  dsh_r,  dsh_nxt;
  logic [CNT_W-1:0]  quo_r,  quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r,  run_nxt;
  logic              done_r, done_nxt;
  logic              ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      // The quotient is below 2^CNT_W, so the divisor starts CNT_W-1 places up.
      dsh_nxt  = {divisor, {(CNT_W-1){1'b0}}};
      quo_nxt  = '0;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt  = {quo_r[CNT_W-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(CNT_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign res.done  = done_r;
  assign res.exact = (rem_r == '0);
  assign res.quot  = quo_r;

endmodule

// ===== rtl/fixed_block_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit
// Pool of equal blocks kept as a linked free list in an on-chip memory.
// ----------------------------------------------------------------------------
// The unit takes one transaction at a time. An allocate or an ownership query
// passes from acceptance to the result through these steps: S_MUL forms the pool
// span and head offset products, S_EVAL evaluates with the head's link read
// from the next-index memory, S_DONE hands the result to the output register.
// The next transaction can be accepted in the cycle in which the result appears.
// A free that lands in the pool then waits in S_DIV while the divider resolves
// one bit of the block index per cycle. A free-all rewrites the chain one link
// per cycle through the memory's write port. A result held by the receiver
// holds the unit in its last step, S_DONE.
// The next-index memory needs no clearing after reset, but free-all must be
// issued after the pool is configured and before the first allocate succeeds.
// A new transaction can be accepted while the previous result still waits.
module fixed_block_free_list_allocator_unit
  import fbfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [SIZE_W-1:0]  in_request_size,
  input  logic [ALIGN_W-1:0] in_alignment,
  input  logic [ADDR_W-1:0]  in_address,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [ADDR_W-1:0]  out_block_address,
  output logic [SIZE_W-1:0]  out_block_length,
  output logic               out_owned,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_EVAL,
    S_DIV,
    S_REBUILD,
    S_DONE
  } state_t;

  // Configuration registers
  logic [ADDR_W-1:0]  base_r;
  logic [SIZE_W-1:0]  size_r;
  logic [CNT_W-1:0]   count_r;
  logic [ALIGN_W-1:0] dalign_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  state_t             state_r,    state_nxt;
  op_t                op_r,       op_nxt;
  logic [SIZE_W-1:0]  req_r,      req_nxt;
  logic [ALIGN_W-1:0] align_r,    align_nxt;
  logic [ADDR_W-1:0]  addr_r,     addr_nxt;
  logic [SPAN_W-1:0]  span_r,     span_nxt;
  logic [HOFF_W-1:0]  hoff_r,     hoff_nxt;
  logic [IDX_W-1:0]   head_r,     head_nxt;
  logic               head_vld_r, head_vld_nxt;
  logic [CNT_W-1:0]   rb_cnt_r,   rb_cnt_nxt;

  status_t            res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]  res_addr_r,   res_addr_nxt;
  logic [SIZE_W-1:0]  res_len_r,    res_len_nxt;
  logic               res_own_r,    res_own_nxt;

  logic               out_valid_r,  out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_addr_r,   out_addr_nxt;
  logic [SIZE_W-1:0]  out_len_r,    out_len_nxt;
  logic               out_own_r,    out_own_nxt;

  logic [SIZE_W-1:0]  eff_size;
  logic [CNT_W-1:0]   eff_cnt;
  logic [CNT_W-1:0]   cnt_last;
  logic [ADDR_W:0]    pool_hi;
  logic               in_pool;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  link_t              ram_wdata;
  link_t              ram_rdata;

  logic               div_start;
  logic [OFF_W-1:0]   div_dividend;
  div_res_t           div_res;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      size_r   <= SIZE_W'(1);
      count_r  <= CNT_W'(1);
      dalign_r <= ALIGN_W'(16);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ARENA_BASE:  base_r   <= pwdata;
        REG_BLOCK_SIZE:  size_r   <= pwdata[SIZE_W-1:0];
        REG_BLOCK_COUNT: count_r  <= pwdata[CNT_W-1:0];
        REG_DEF_ALIGN:   dalign_r <= pwdata[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ARENA_BASE:  prdata = base_r;
      REG_BLOCK_SIZE:  prdata = DATA_W'(size_r);
      REG_BLOCK_COUNT: prdata = DATA_W'(count_r);
      REG_DEF_ALIGN:   prdata = DATA_W'(dalign_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective pool geometry
  // ---------------------------------------------------------------------------
  always_comb begin
    if (size_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(size_r) > SIZE_MAX) begin
      eff_size = SIZE_W'(SIZE_MAX);
    end else begin
      eff_size = size_r;
    end
    if (count_r == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (32'(count_r) > MAX_BLOCKS) begin
      eff_cnt = CNT_W'(MAX_BLOCKS);
    end else begin
      eff_cnt = count_r;
    end
  end

  assign cnt_last = eff_cnt - 1'b1;

  // The upper bound is kept one bit wider so a pool past 2^32 never wraps.
  assign pool_hi      = {1'b0, base_r} + (ADDR_W+1)'(span_r);
  assign in_pool      = (addr_r >= base_r) && ({1'b0, addr_r} < pool_hi);
  assign div_dividend = OFF_W'(addr_r - base_r);

  // ---------------------------------------------------------------------------
  // Memory and divider
  // ---------------------------------------------------------------------------
  fbfl_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  fbfl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_size),
    .res      (div_res)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    align_nxt      = align_r;
    addr_nxt       = addr_r;
    span_nxt       = span_r;
    hoff_nxt       = hoff_r;
    head_nxt       = head_r;
    head_vld_nxt   = head_vld_r;
    rb_cnt_nxt     = rb_cnt_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_len_nxt    = res_len_r;
    res_own_nxt    = res_own_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_len_nxt    = out_len_r;
    out_own_nxt    = out_own_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    div_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = op_t'(in_operation);
          req_nxt        = in_request_size;
          align_nxt      = in_alignment;
          addr_nxt       = in_address;
          res_status_nxt = ST_OK;
          res_addr_nxt   = '0;
          res_len_nxt    = '0;
          res_own_nxt    = 1'b0;
          state_nxt      = S_MUL;
        end
      end

      // The head's link is read from memory in this cycle as well.
      S_MUL: begin
        span_nxt  = SPAN_W'(eff_cnt) * SPAN_W'(eff_size);
        hoff_nxt  = HOFF_W'(head_r) * HOFF_W'(eff_size);
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        case (op_r)
          OP_ALLOC: begin
            if (align_r <= dalign_r && req_r <= eff_size && head_vld_r) begin
              res_addr_nxt = base_r + ADDR_W'(hoff_r);
              res_len_nxt  = eff_size;
              head_vld_nxt = !ram_rdata.last;
              head_nxt     = ram_rdata.idx;
            end else begin
              res_status_nxt = ST_REFUSED;
            end
            state_nxt = S_DONE;
          end
          OP_FREE: begin
            if (!in_pool) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_DONE;
            end else begin
              res_own_nxt = 1'b1;
              div_start   = 1'b1;
              state_nxt   = S_DIV;
            end
          end
          OP_REBUILD: begin
            rb_cnt_nxt = '0;
            state_nxt  = S_REBUILD;
          end
          default: begin
            res_own_nxt = in_pool;
            state_nxt   = S_DONE;
          end
        endcase
      end

      S_DIV: begin
        if (div_res.done) begin
          if (!div_res.exact) begin
            res_status_nxt = ST_MISALIGN;
          end else begin
            // Push the freed block in front of the current head.
            ram_we         = 1'b1;
            ram_waddr      = IDX_W'(div_res.quot);
            ram_wdata.last = !head_vld_r;
            ram_wdata.idx  = head_vld_r ? head_r : '0;
            head_nxt       = IDX_W'(div_res.quot);
            head_vld_nxt   = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end

      S_REBUILD: begin
        ram_we     = 1'b1;
        ram_waddr  = IDX_W'(rb_cnt_r);
        rb_cnt_nxt = rb_cnt_r + 1'b1;
        if (rb_cnt_r == cnt_last) begin
          ram_wdata.last = 1'b1;
          ram_wdata.idx  = '0;
          head_nxt       = '0;
          head_vld_nxt   = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          ram_wdata.last = 1'b0;
          ram_wdata.idx  = IDX_W'(rb_cnt_r + 1'b1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_len_nxt    = res_len_r;
          out_own_nxt    = res_own_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      head_vld_r   <= 1'b0;
      rb_cnt_r     <= '0;
      out_valid_r  <= 1'b0;
      op_r         <= OP_ALLOC;
      req_r        <= '0;
      align_r      <= '0;
      addr_r       <= '0;
      span_r       <= '0;
      hoff_r       <= '0;
      res_status_r <= ST_OK;
      res_addr_r   <= '0;
      res_len_r    <= '0;
      res_own_r    <= 1'b0;
      out_status_r <= '0;
      out_addr_r   <= '0;
      out_len_r    <= '0;
      out_own_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      head_vld_r   <= head_vld_nxt;
      rb_cnt_r     <= rb_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      req_r        <= req_nxt;
      align_r      <= align_nxt;
      addr_r       <= addr_nxt;
      span_r       <= span_nxt;
      hoff_r       <= hoff_nxt;
      res_status_r <= res_status_nxt;
      res_addr_r   <= res_addr_nxt;
      res_len_r    <= res_len_nxt;
      res_own_r    <= res_own_nxt;
      out_status_r <= out_status_nxt;
      out_addr_r   <= out_addr_nxt;
      out_len_r    <= out_len_nxt;
      out_own_r    <= out_own_nxt;
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_block_length  = out_len_r;
  assign out_owned         = out_own_r;

endmodule

// ===== rtl/fbfl_checker.sv =====
// ----------------------------------------------------------------------------
// fbfl_checker
// Port-level checks of the block pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbfl_checker
  import fbfl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic [ADDR_W-1:0] out_block_address,
  input logic [SIZE_W-1:0] out_block_length,
  input logic              out_owned
);

  // A result held back by the receiver stays valid and keeps its status, address and length.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
                               $stable(out_block_address) && $stable(out_block_length))
    else $error("stalled result changed");

  // Only a granted allocation carries an address or a length.
  a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_block_address == '0 && out_block_length == '0)
    else $error("non-ok result carries a block");

  // An out-of-range free is never owned; a misaligned one always is.
  a_owned_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RANGE || out_status == ST_MISALIGN)
      |-> out_owned == (out_status == ST_MISALIGN))
    else $error("owned flag disagrees with status");

  // The unit works on one transaction at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

endmodule

bind fixed_block_free_list_allocator_unit fbfl_checker u_fbfl_checker (.*);

// ===== bench/fbfl_pool_monitor.sv =====
// ----------------------------------------------------------------------------
// fbfl_pool_monitor
// Watches the request, result and register ports of the block pool
// allocator. It keeps its own copy of the pool registers and the free list,
// works out the reply each accepted request should get, and compares every
// accepted result with the oldest reply still owed.
// ----------------------------------------------------------------------------
module fbfl_pool_monitor
  import fbfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [SIZE_W-1:0]  in_request_size,
  input  logic [ALIGN_W-1:0] in_alignment,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic [ADDR_W-1:0]  out_block_address,
  input  logic [SIZE_W-1:0]  out_block_length,
  input  logic               out_owned,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 replies_owed
);

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] block_length;
    logic              owned;
  } pool_reply_t;

  logic [ADDR_W-1:0]  arena_base;
  logic [SIZE_W-1:0]  blk_bytes;
  logic [CNT_W-1:0]   block_count;
  logic [ALIGN_W-1:0] def_align;

  logic               head_valid;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   link_next [MAX_BLOCKS];
  logic               link_last [MAX_BLOCKS];

  pool_reply_t        owed_q [$];
  int                 errs = 0;

  function automatic logic [SIZE_W-1:0] stride();
    if (blk_bytes == '0) return SIZE_W'(1);
    if (blk_bytes > SIZE_W'(SIZE_MAX)) return SIZE_W'(SIZE_MAX);
    return blk_bytes;
  endfunction

  function automatic logic [CNT_W-1:0] blocks();
    if (block_count == '0) return CNT_W'(1);
    if (block_count > CNT_W'(MAX_BLOCKS)) return CNT_W'(MAX_BLOCKS);
    return block_count;
  endfunction

  // The upper bound is formed in 64 bits, so a pool running past the top of
  // the address space owns nothing beyond it.
  function automatic logic in_arena(logic [ADDR_W-1:0] a);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = 64'(arena_base);
    hi = lo + 64'(blocks()) * 64'(stride());
    return (64'(a) >= lo) && (64'(a) < hi);
  endfunction

  function automatic pool_reply_t pool_step(op_t op, logic [SIZE_W-1:0] req,
                                            logic [ALIGN_W-1:0] al,
                                            logic [ADDR_W-1:0] addr);
    pool_reply_t      r;
    logic [SIZE_W-1:0] sz;
    int               n;
    logic [ADDR_W-1:0] off;
    logic [IDX_W-1:0] idx;
    r  = '0;
    sz = stride();
    case (op)
      OP_ALLOC: begin
        if (al <= def_align && req <= sz && head_valid) begin
          idx             = head;
          r.block_address = arena_base + ADDR_W'(idx) * ADDR_W'(sz);
          r.block_length  = sz;
          head_valid      = !link_last[idx];
          head            = link_next[idx];
        end else begin
          r.status = ST_REFUSED;
        end
      end
      OP_FREE: begin
        if (!in_arena(addr)) begin
          r.status = ST_RANGE;
        end else begin
          r.owned = 1'b1;
          off     = addr - arena_base;
          if (off % sz != 0) begin
            r.status = ST_MISALIGN;
          end else begin
            // A double free is not caught: the block is simply pushed again.
            idx            = IDX_W'(off / sz);
            link_last[idx] = !head_valid;
            link_next[idx] = head_valid ? head : '0;
            head           = idx;
            head_valid     = 1'b1;
          end
        end
      end
      OP_REBUILD: begin
        n = int'(blocks());
        for (int i = 0; i < n - 1; i++) begin
          link_next[i] = IDX_W'(i + 1);
          link_last[i] = 1'b0;
        end
        link_next[n-1] = '0;
        link_last[n-1] = 1'b1;
        head           = '0;
        head_valid     = 1'b1;
      end
      default: begin
        r.owned = in_arena(addr);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pool_reply_t want;
    if (!rst_n) begin
      arena_base  = '0;
      blk_bytes   = SIZE_W'(1);
      block_count = CNT_W'(1);
      def_align   = ALIGN_W'(16);
      head_valid  = 1'b0;
      head        = '0;
      owed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_ARENA_BASE:  arena_base  = pwdata[ADDR_W-1:0];
          REG_BLOCK_SIZE:  blk_bytes   = pwdata[SIZE_W-1:0];
          REG_BLOCK_COUNT: block_count = pwdata[CNT_W-1:0];
          REG_DEF_ALIGN:   def_align   = pwdata[ALIGN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("result transaction arrived with no request waiting for it");
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errs++;
          end
          if (out_block_address !== want.block_address) begin
            $error("block_address: expected %h, actual %h",
                   want.block_address, out_block_address);
            errs++;
          end
          if (out_block_length !== want.block_length) begin
            $error("block_length: expected %0d, actual %0d",
                   want.block_length, out_block_length);
            errs++;
          end
          if (out_owned !== want.owned) begin
            $error("owned: expected %0d, actual %0d", want.owned, out_owned);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        owed_q.push_back(pool_step(op_t'(in_operation), in_request_size,
                                   in_alignment, in_address));
      end
    end
    fail_count   <= errs;
    replies_owed <= owed_q.size();
  end

endmodule

// ===== bench/tb_fixed_block_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator_unit
// Drives the block pool allocator with directed and random request
// transactions over a range of pool settings, with random gaps on both
// channels and one long hold-off on the result side, and reports the verdict
// of the pool monitor.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator_unit;
  import fbfl_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_operation;
  logic [SIZE_W-1:0]  in_request_size;
  logic [ALIGN_W-1:0] in_alignment;
  logic [ADDR_W-1:0]  in_address;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [ADDR_W-1:0]  out_block_address;
  logic [SIZE_W-1:0]  out_block_length;
  logic               out_owned;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int                 fail_count;
  int                 replies_owed;
  int                 quiet = 0;
  bit                 steady = 1'b0;
  bit                 pressure = 1'b0;
  bit                 hold_done = 1'b0;
  int                 hold_left = 0;

  always #5 clk = ~clk;

  fixed_block_free_list_allocator_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_request_size   (in_request_size),
    .in_alignment      (in_alignment),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_block_length  (out_block_length),
    .out_owned         (out_owned),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  fbfl_pool_monitor pool_mon (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_request_size   (in_request_size),
    .in_alignment      (in_alignment),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_block_length  (out_block_length),
    .out_owned         (out_owned),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .fail_count        (fail_count),
    .replies_owed      (replies_owed)
  );

  // Result side: random stalls, none while steady, and one long hold-off
  // once pressure is requested so that the unit backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (pressure && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 32);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Leaves in_valid high after acceptance; the next call or the caller
  // decides in the same step whether it stays up.
  task automatic send(op_t op, logic [SIZE_W-1:0] req, logic [ALIGN_W-1:0] al,
                      logic [ADDR_W-1:0] addr);
    if (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 32) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_request_size <= req;
    in_alignment    <= al;
    in_address      <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly block starts inside the pool, with some misaligned offsets,
  // addresses just outside either end, and fully random ones.
  function automatic logic [ADDR_W-1:0] pick_address(logic [ADDR_W-1:0] base,
                                                     logic [SIZE_W-1:0] esz,
                                                     logic [CNT_W-1:0] ecnt);
    logic [ADDR_W-1:0] k;
    int                s;
    k = $urandom_range(0, ecnt - 1);
    s = $urandom_range(0, 9);
    if (s < 7) return base + k * esz;
    if (s == 7) begin
      if (esz > 1) return base + k * esz + $urandom_range(1, esz - 1);
      return base + ecnt * esz;
    end
    if (s == 8) return $urandom_range(0, 1) ? base + ecnt * esz : base - 1;
    return $urandom;
  endfunction

  task automatic run_phase(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] sz,
                           logic [CNT_W-1:0] cnt, logic [ALIGN_W-1:0] dal,
                           int n_items, bit fresh);
    logic [SIZE_W-1:0]  esz;
    logic [CNT_W-1:0]   ecnt;
    logic [SIZE_W-1:0]  rq;
    logic [ALIGN_W-1:0] al;
    int                 r;
    int                 s;
    esz  = (sz == 0) ? SIZE_W'(1) : ((sz > SIZE_W'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX) : sz);
    ecnt = (cnt == 0) ? CNT_W'(1) : ((cnt > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cnt);
    wait_idle();
    reg_write(REG_ARENA_BASE, base);
    reg_write(REG_BLOCK_SIZE, DATA_W'(sz));
    reg_write(REG_BLOCK_COUNT, DATA_W'(cnt));
    reg_write(REG_DEF_ALIGN, DATA_W'(dal));
    if (fresh) send(OP_REBUILD, SIZE_W'($urandom), ALIGN_W'($urandom), $urandom);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 9);
      if (s < 7)       rq = SIZE_W'($urandom_range(0, esz));
      else if (s == 7) rq = esz;
      else if (s == 8) rq = SIZE_W'(esz + 1);
      else             rq = SIZE_W'($urandom);
      s = $urandom_range(0, 9);
      if (s < 7)       al = ALIGN_W'($urandom_range(0, dal));
      else if (s == 7) al = dal;
      else if (s == 8) al = ALIGN_W'(dal + 1);
      else             al = ALIGN_W'($urandom);
      if (r < 38)      send(OP_ALLOC, rq, al, $urandom);
      else if (r < 68) send(OP_FREE, rq, al, pick_address(base, esz, ecnt));
      else if (r < 72) send(OP_REBUILD, rq, al, $urandom);
      else             send(OP_QUERY, rq, al, pick_address(base, esz, ecnt));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_QUERY;
    in_request_size = '0;
    in_alignment    = '0;
    in_address      = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the list is empty until a block is freed or rebuilt.
    send(OP_ALLOC, '0, '0, '0);
    send(OP_QUERY, '0, '0, '0);
    send(OP_QUERY, '1, '1, 32'd1);
    send(OP_FREE, '0, '0, '0);
    send(OP_ALLOC, SIZE_W'(1), ALIGN_W'(16), '0);
    send(OP_ALLOC, '0, '0, '0);
    send(OP_FREE, '0, '0, 32'hFFFF_FFFF);
    in_valid <= 1'b0;

    wait_idle();
    reg_write(REG_ARENA_BASE, 32'h8000_0000);
    reg_write(REG_BLOCK_SIZE, 32'd16);
    reg_write(REG_BLOCK_COUNT, 32'd4);
    reg_write(REG_DEF_ALIGN, 32'd8);
    send(OP_REBUILD, '1, '1, 32'hFFFF_FFFF);
    send(OP_ALLOC, SIZE_W'(16), ALIGN_W'(8), '0);
    send(OP_ALLOC, SIZE_W'(17), '0, '0);
    send(OP_ALLOC, '0, ALIGN_W'(9), '0);
    send(OP_ALLOC, '1, '1, '0);
    send(OP_ALLOC, '0, '0, '0);
    send(OP_FREE, '0, '0, 32'h8000_0008);
    send(OP_FREE, '0, '0, 32'h7FFF_FFFF);
    send(OP_FREE, '0, '0, 32'h8000_0040);
    send(OP_QUERY, '0, '0, 32'h8000_003F);
    send(OP_QUERY, '0, '0, 32'hFFFF_FFFF);
    // The same block freed twice ends up on the list twice.
    send(OP_FREE, '0, '0, 32'h8000_0010);
    send(OP_FREE, '0, '0, 32'h8000_0010);
    send(OP_ALLOC, SIZE_W'(16), ALIGN_W'(8), '0);
    send(OP_ALLOC, '0, '0, '0);
    send(OP_ALLOC, '0, '0, '0);
    send(OP_ALLOC, '0, '0, '0);
    send(OP_ALLOC, '0, '0, '0);
    in_valid <= 1'b0;

    run_phase(32'h0000_1000, 17'd64, 11'd8, 13'd16, 80, 1'b1);
    run_phase(32'h0000_0000, 17'd0, 11'd0, 13'd0, 40, 1'b1);
    steady <= 1'b1;
    // This pool runs past the top of the address space.
    run_phase(32'hFFFF_F000, 17'd256, 11'd32, 13'd4096, 80, 1'b1);
    steady <= 1'b0;
    run_phase($urandom, 17'd65536, 11'd4, 13'd8191, 60, 1'b1);
    run_phase($urandom, 17'h1FFFF, 11'd2047, 13'd1, 40, 1'b1);
    pressure <= 1'b1;
    run_phase($urandom, 17'd3, 11'd16, 13'd16, 100, 1'b1);
    // New settings over the old chain, with no rebuild first.
    run_phase(32'h0000_2000, 17'd48, 11'd12, 13'd32, 60, 1'b0);
    run_phase(32'hFFFF_FFFF, 17'd1, 11'd1024, 13'd4096, 60, 1'b1);
    repeat (3) begin
      run_phase($urandom, SIZE_W'($urandom_range(1, 4096)),
                CNT_W'($urandom_range(1, 64)),
                ALIGN_W'($urandom_range(1, 4096)), 40, 1'b1);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && replies_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== fixed_block_free_list_allocator_unit.f =====
rtl/fbfl_pkg.sv
rtl/fbfl_ram.sv
rtl/fbfl_div.sv
rtl/fixed_block_free_list_allocator_unit.sv
rtl/fbfl_checker.sv
bench/fbfl_pool_monitor.sv
bench/tb_fixed_block_free_list_allocator_unit.sv
